>>> src/rilp_pkg.sv
// Shared types and constants for the radix integer literal parser.
// Used by rilp_step and radix_integer_literal_parser; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rilp_pkg;

    // Fixed widths of the beat fields
    localparam int CHAR_WIDTH  = 21;
    localparam int VALUE_WIDTH = 64;
    localparam int RADIX_WIDTH = 6;

    // Character codes
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 21'd45;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 21'd48;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 21'd57;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 21'd65;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_Z = 21'd90;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_R = 21'd114;

    // Letter digits start at ten; the radix prefix may be at most 36
    localparam logic [RADIX_WIDTH-1:0] LETTER_BASE = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] MAX_RADIX   = 6'd36;

    // Parse phase, one-hot
    typedef enum logic [6:0] {
        PH_FIRST      = 7'b0000001,
        PH_DEC        = 7'b0000010,
        PH_RAD_FIRST  = 7'b0000100,
        PH_RAD        = 7'b0001000,
        PH_DONE_DEC   = 7'b0010000,
        PH_DONE_RAD   = 7'b0100000,
        PH_DONE_FAULT = 7'b1000000
    } phase_t;

    // Control part of the parse state
    typedef struct packed {
        phase_t                 phase;
        logic                   outer_neg;
        logic                   inner_neg;
        logic [RADIX_WIDTH-1:0] radix;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{
        phase:     PH_FIRST,
        outer_neg: 1'b0,
        inner_neg: 1'b0,
        radix:     '0
    };

endpackage

`default_nettype wire

>>> src/radix_integer_literal_parser.sv
// Top level of the radix integer literal parser: input register, parse state
// registers and result register around rilp_step; depends on rilp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Ports                            | Beat
// s_      | in        | s_valid s_ready s_char_code      | one character of the literal,
//         |           | s_last_char                      | s_last_char on the final one
// m_      | out       | m_valid m_ready m_value          | one result per literal
//         |           | m_bad_radix                      |
//
// One character is taken every cycle unless a final character stalls: the
// single-character step (times-ten shift-add, times-radix multiply) sits between the
// input and state registers, and feeds the result register on a final character.
// Synchronous active-low reset clears both beat valid flags and the parse state.
// A final character waits in the input register only while the result register
// holds an untaken beat; other characters never stall.

module radix_integer_literal_parser #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [rilp_pkg::CHAR_WIDTH-1:0]        s_char_code,
    input  wire logic                                   s_last_char,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [rilp_pkg::VALUE_WIDTH-1:0]     m_value,
    output logic                                        m_bad_radix
);
    import rilp_pkg::*;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [CHAR_WIDTH-1:0]  in_char_reg;
    logic                   in_last_reg;
    ctrl_t                  ctrl_reg;
    ctrl_t                  ctrl_next;
    logic [VALUE_BITS-1:0]  dec_reg;
    logic [VALUE_BITS-1:0]  dec_next;
    logic [VALUE_BITS-1:0]  rad_reg;
    logic [VALUE_BITS-1:0]  rad_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic signed [VALUE_WIDTH-1:0] m_value_reg;
    logic                   m_bad_reg;
    logic signed [VALUE_WIDTH-1:0] res_value;
    logic                   res_bad_radix;
    logic                   s_fire;
    logic                   advance;

    // Handshake: a character steps unless it must emit into a full result slot
    assign advance = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign in_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && in_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Character step
    rilp_step #(
        .VALUE_BITS(VALUE_BITS)
    ) u_step (
        .char_code     (in_char_reg),
        .last_char     (in_last_reg),
        .ctrl_in       (ctrl_reg),
        .dec_in        (dec_reg),
        .rad_in        (rad_reg),
        .ctrl_out      (ctrl_next),
        .dec_out       (dec_next),
        .rad_out       (rad_next),
        .res_value     (res_value),
        .res_bad_radix (res_bad_radix)
    );

    // Control and parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            ctrl_reg     <= CTRL_RESET;
            dec_reg      <= '0;
            rad_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                ctrl_reg <= ctrl_next;
                dec_reg  <= dec_next;
                rad_reg  <= rad_next;
            end
        end
    end

    // Beat payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_last_char;
        end
        if (advance && in_last_reg) begin
            m_value_reg <= res_value;
            m_bad_reg   <= res_bad_radix;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_bad_radix = m_bad_reg;

endmodule

`default_nettype wire

>>> src/rilp_step.sv
// One character step of the literal parser: next state and the result beat.
// Pure combinational logic; depends on rilp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rilp_step #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic [rilp_pkg::CHAR_WIDTH-1:0]  char_code,
    input  wire logic                             last_char,
    input  wire rilp_pkg::ctrl_t                  ctrl_in,
    input  wire logic [VALUE_BITS-1:0]            dec_in,
    input  wire logic [VALUE_BITS-1:0]            rad_in,
    output rilp_pkg::ctrl_t                       ctrl_out,
    output logic [VALUE_BITS-1:0]                 dec_out,
    output logic [VALUE_BITS-1:0]                 rad_out,
    output logic signed [rilp_pkg::VALUE_WIDTH-1:0] res_value,
    output logic                                  res_bad_radix
);
    import rilp_pkg::*;

    logic                   is_dec;
    logic                   is_digit;
    logic [RADIX_WIDTH-1:0] digit;
    logic                   rad_digit_ok;
    logic [VALUE_BITS-1:0]  dec_acc;
    logic [VALUE_BITS-1:0]  rad_acc;
    ctrl_t                  ctrl_step;
    logic [VALUE_BITS-1:0]  dec_step;
    logic [VALUE_BITS-1:0]  rad_step;
    logic                   in_radix_part;
    logic [VALUE_BITS-1:0]  mag;
    logic [VALUE_BITS-1:0]  inner_val;
    logic [VALUE_BITS-1:0]  outer_val;
    logic signed [VALUE_BITS-1:0] outer_signed;

    // Digit decode: 0-9 and A-Z only
    always_comb begin
        is_dec   = 1'b0;
        is_digit = 1'b0;
        digit    = '0;
        if (char_code inside {[CH_ZERO:CH_NINE]}) begin
            is_dec   = 1'b1;
            is_digit = 1'b1;
            digit    = RADIX_WIDTH'(char_code - CH_ZERO);
        end else if (char_code inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            is_digit = 1'b1;
            digit    = RADIX_WIDTH'(char_code - CH_UPPER_A) + LETTER_BASE;
        end
    end

    // Accumulators: times ten by shift-add, times radix by a narrow multiply
    assign dec_acc      = (dec_in << 3) + (dec_in << 1) + VALUE_BITS'(digit);
    assign rad_acc      = rad_in * VALUE_BITS'(ctrl_in.radix) + VALUE_BITS'(digit);
    assign rad_digit_ok = is_digit && (digit < ctrl_in.radix);

    // Phase sequencing for one character
    always_comb begin
        ctrl_step = ctrl_in;
        dec_step  = dec_in;
        rad_step  = rad_in;
        case (ctrl_in.phase)
            PH_FIRST, PH_DEC: begin
                if (ctrl_in.phase == PH_FIRST && char_code == CH_MINUS) begin
                    ctrl_step.outer_neg = 1'b1;
                    ctrl_step.phase     = PH_DEC;
                end else if (is_dec) begin
                    dec_step        = dec_acc;
                    ctrl_step.phase = PH_DEC;
                end else if (char_code == CH_LOWER_R) begin
                    if (dec_in > VALUE_BITS'(MAX_RADIX)) begin
                        ctrl_step.phase = PH_DONE_FAULT;
                    end else begin
                        ctrl_step.radix = dec_in[RADIX_WIDTH-1:0];
                        ctrl_step.phase = PH_RAD_FIRST;
                    end
                end else begin
                    ctrl_step.phase = PH_DONE_DEC;
                end
            end
            PH_RAD_FIRST, PH_RAD: begin
                if (ctrl_in.phase == PH_RAD_FIRST && char_code == CH_MINUS) begin
                    ctrl_step.inner_neg = 1'b1;
                    ctrl_step.phase     = PH_RAD;
                end else if (rad_digit_ok) begin
                    rad_step        = rad_acc;
                    ctrl_step.phase = PH_RAD;
                end else begin
                    ctrl_step.phase = PH_DONE_RAD;
                end
            end
            default: begin
                // finished phases hold until the final character
            end
        endcase
    end

    // Result from the stepped state
    assign in_radix_part = (ctrl_step.phase == PH_RAD_FIRST) ||
                           (ctrl_step.phase == PH_RAD) ||
                           (ctrl_step.phase == PH_DONE_RAD);
    assign inner_val     = ctrl_step.inner_neg ? (~rad_step + VALUE_BITS'(1)) : rad_step;
    assign mag           = in_radix_part ? inner_val : dec_step;
    assign outer_val     = ctrl_step.outer_neg ? (~mag + VALUE_BITS'(1)) : mag;
    assign outer_signed  = outer_val;

    always_comb begin
        if (ctrl_step.phase == PH_DONE_FAULT) begin
            res_value     = '0;
            res_bad_radix = 1'b1;
        end else begin
            res_value     = VALUE_WIDTH'(outer_signed);
            res_bad_radix = 1'b0;
        end
    end

    // The final character returns the parser to its start state
    assign ctrl_out = last_char ? CTRL_RESET : ctrl_step;
    assign dec_out  = last_char ? '0 : dec_step;
    assign rad_out  = last_char ? '0 : rad_step;

endmodule

`default_nettype wire
